[design/stb_pkg.sv]
// stb_pkg: shared sizes, operation codes and command types for the timer bank
`timescale 1ns / 1ps

package stb_pkg;

    // bank size and counter width
    localparam int NUM_TIMERS  = 8;
    localparam int COUNT_WIDTH = 32;

    // fixed item field widths
    localparam int OP_W    = 2;
    localparam int INDEX_W = 4;
    localparam int LOAD_W  = 32;

    // index compare is one bit wider than the index field
    localparam int CMP_W = INDEX_W + 1;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    // commands from controller to datapath
    typedef struct packed {
        logic tick;
        logic set;
        logic clear;
        logic capture;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic index_ok;
    } stat_t;

endpackage

[design/stb_if.sv]
// stb_if: valid/ready channels for timer bank request and response items
`timescale 1ns / 1ps

interface stb_req_if;
    logic                        valid;
    logic                        ready;
    logic [stb_pkg::OP_W-1:0]    operation;
    logic [stb_pkg::INDEX_W-1:0] timer_index;
    logic [stb_pkg::LOAD_W-1:0]  load_count;

    modport source (output valid, output operation, output timer_index,
                    output load_count, input ready);
    modport sink   (input valid, input operation, input timer_index,
                    input load_count, output ready);
endinterface

interface stb_rsp_if;
    logic valid;
    logic ready;
    logic expired;

    modport source (output valid, output expired, input ready);
    modport sink   (input valid, input expired, output ready);
endinterface

[design/stb_ctrl.sv]
// stb_ctrl: handshake controller, decodes each item into datapath commands
`timescale 1ns / 1ps

module stb_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [stb_pkg::OP_W-1:0] operation,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  stb_pkg::stat_t           stat,
    output stb_pkg::cmd_t            cmd
);

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    stb_pkg::op_t  op;
    logic          accept;

    // a new item enters when the result slot is free or being emptied
    assign in_ready  = (state_reg == ST_EMPTY) || out_ready;
    assign out_valid = (state_reg == ST_FULL);
    assign accept    = in_valid && in_ready;
    assign op        = stb_pkg::op_t'(operation);

    // command decode
    always_comb
    begin
        cmd = '0;
        if (accept)
        begin
            case (op)
                stb_pkg::OP_TICK:  cmd.tick    = 1'b1;
                stb_pkg::OP_SET:   cmd.set     = stat.index_ok;
                stb_pkg::OP_CLEAR: cmd.clear   = stat.index_ok;
                stb_pkg::OP_QUERY: cmd.capture = 1'b1;
                default:           cmd         = '0;
            endcase
        end
    end

    // result slot occupancy
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY:
            begin
                if (accept && op == stb_pkg::OP_QUERY)
                    state_next = ST_FULL;
            end
            ST_FULL:
            begin
                if (accept && op == stb_pkg::OP_QUERY)
                    state_next = ST_FULL;
                else if (out_ready)
                    state_next = ST_EMPTY;
            end
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_EMPTY;
        else
            state_reg <= state_next;
    end

endmodule

[design/stb_datapath.sv]
// stb_datapath: timer counters, running flags and the query result register
`timescale 1ns / 1ps

module stb_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stb_pkg::cmd_t               cmd,
    output stb_pkg::stat_t              stat,
    input  logic [stb_pkg::INDEX_W-1:0] timer_index,
    input  logic [stb_pkg::LOAD_W-1:0]  load_count,
    output logic                        expired
);

    stb_pkg::count_t                  count_reg   [stb_pkg::NUM_TIMERS];
    stb_pkg::count_t                  count_next  [stb_pkg::NUM_TIMERS];
    logic [stb_pkg::NUM_TIMERS-1:0]   running_reg;
    logic [stb_pkg::NUM_TIMERS-1:0]   running_next;
    logic [stb_pkg::NUM_TIMERS-1:0]   hit;
    logic [stb_pkg::NUM_TIMERS-1:0]   done;
    logic                             expired_reg;
    stb_pkg::count_t                  load_ext;

    // index range check
    assign stat.index_ok = {1'b0, timer_index} < stb_pkg::CMP_W'(stb_pkg::NUM_TIMERS);

    // load cast to the counter width
    assign load_ext = stb_pkg::count_t'(load_count);

    // per-timer select and expiry
    always_comb
    begin
        for (int t = 0; t < stb_pkg::NUM_TIMERS; t++)
        begin
            hit[t]  = stat.index_ok && ({1'b0, timer_index} == stb_pkg::CMP_W'(t));
            done[t] = running_reg[t] && (count_reg[t] == '0);
        end
    end

    // next counter and flag values
    always_comb
    begin
        for (int t = 0; t < stb_pkg::NUM_TIMERS; t++)
        begin
            count_next[t]   = count_reg[t];
            running_next[t] = running_reg[t];
            if (cmd.tick && count_reg[t] != '0)
                count_next[t] = count_reg[t] - stb_pkg::count_t'(1);
            if (cmd.set && hit[t])
            begin
                count_next[t]   = load_ext;
                running_next[t] = 1'b1;
            end
            if (cmd.clear && hit[t])
                running_next[t] = 1'b0;
        end
    end

    // timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < stb_pkg::NUM_TIMERS; t++)
                count_reg[t] <= '0;
            running_reg <= '0;
        end
        else
        begin
            for (int t = 0; t < stb_pkg::NUM_TIMERS; t++)
                count_reg[t] <= count_next[t];
            running_reg <= running_next;
        end
    end

    // query result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            expired_reg <= |(hit & done);
    end

    assign expired = expired_reg;

endmodule

[design/software_timer_bank.sv]
// software_timer_bank: top level of the eight-entry down-counting timer bank
//
//  channel   | dir | fields                                  | result
//  ----------+-----+-----------------------------------------+-----------------
//  request   | in  | operation, timer_index, load_count      | query gives one
//  response  | out | expired                                 | one per query
//
//  a new item may follow each cycle unless a stalled result holds request.ready low
//  a query result sits in the response register from the next cycle on
//  while that result is stalled, request.ready is low
//  ticks decrement every nonzero counter in parallel in the cycle the item is taken
//  reset clears all counts, running flags and the response slot at once
`timescale 1ns / 1ps

module software_timer_bank (
    input  logic      clk,
    input  logic      rst_n,
    stb_req_if.sink   request,
    stb_rsp_if.source response
);

    stb_pkg::cmd_t  cmd;
    stb_pkg::stat_t stat;

    // handshake and command decode
    stb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .operation (request.operation),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // counters and result
    stb_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .timer_index (request.timer_index),
        .load_count  (request.load_count),
        .expired     (response.expired)
    );

endmodule

[design/stb_checker.sv]
// stb_checker: port-level assertions for the timer bank, bound to the top level
`timescale 1ns / 1ps

module stb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic [stb_pkg::OP_W-1:0]    req_operation,
    input logic [stb_pkg::INDEX_W-1:0] req_timer_index,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_expired
);

    logic query_in;
    logic other_in;
    logic bad_index;

    assign query_in  = req_valid && req_ready
                       && (req_operation == stb_pkg::OP_QUERY);
    assign other_in  = req_valid && req_ready
                       && (req_operation != stb_pkg::OP_QUERY);
    assign bad_index = {1'b0, req_timer_index}
                       >= stb_pkg::CMP_W'(stb_pkg::NUM_TIMERS);

    // a query item always yields a result next cycle
    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        query_in |=> rsp_valid)
        else $error("query item gave no result");

    // other items produce no result once the slot drains
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        other_in && (!rsp_valid || rsp_ready) |=> !rsp_valid)
        else $error("result without query item");

    // a stalled result blocks new items
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("item accepted while result stalled");

    // out-of-range query reports not expired
    a_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
        query_in && bad_index |=> !rsp_expired)
        else $error("out-of-range query reported expired");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_expired))
        else $error("stalled result changed");

endmodule

bind software_timer_bank stb_checker u_stb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (request.valid),
    .req_ready       (request.ready),
    .req_operation   (request.operation),
    .req_timer_index (request.timer_index),
    .rsp_valid       (response.valid),
    .rsp_ready       (response.ready),
    .rsp_expired     (response.expired)
);
